### src/bta_pkg.sv
// Shared types and codes for the block table allocator.
// Holds the request/response transaction structs and the action and status codes.
// No dependencies.
package bta_pkg;

   // Action codes carried by a request transaction
   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_USAGE = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   // Status codes carried by a response transaction
   localparam logic [1:0] STS_DONE    = 2'd0;
   localparam logic [1:0] STS_NO_RUN  = 2'd1;
   localparam logic [1:0] STS_ZERO    = 2'd2;
   localparam logic [1:0] STS_OUTSIDE = 2'd3;

   // Usage is reported in whole percent
   localparam int unsigned PERCENT_SCALE = 100;

   // Block count of a request: a 16-bit byte size rounded up can reach 65535
   localparam int unsigned NEED_W = 17;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] request_bytes;
      logic [15:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] grant_offset;
      logic [6:0]  used_percent;
   } rsp_type;

endpackage

### src/block_table_allocator.sv
// Block table allocator: run-length map, one entry per pool block, walked by a sequencer.
// Depends on bta_pkg. Allocate scans the map down from the top entry until a run fits, then marks
//   each entry of the run; free clears the entries of the run; usage, zero size, oversize and
//   outside offset go straight to the percent step; clear sweeps the whole map first.
// busy drops with the strobe, and a new transaction is taken only once busy is low; the receiver cannot stall.
// Reset holds the map sweep at entry 0; after release busy stays high while it clears the map.
module block_table_allocator #(
   parameter int unsigned TABLE_ENTRIES = 256,
   parameter int unsigned BLOCK_BYTES   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bta_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bta_pkg::rsp_type rsp_data
);

   localparam int unsigned ADDR_W     = $clog2(TABLE_ENTRIES);
   localparam int unsigned MAP_W      = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned RUNB_W     = $clog2(TABLE_ENTRIES * BLOCK_BYTES + 1);
   localparam int unsigned PROD_W     = $clog2(TABLE_ENTRIES * bta_pkg::PERCENT_SCALE + 1);
   localparam int unsigned IDX_SHIFT  = 16 + $clog2(BLOCK_BYTES);
   localparam int unsigned IDX_PROD_W = IDX_SHIFT + 17;
   localparam int unsigned PCT_SHIFT  = PROD_W + $clog2(TABLE_ENTRIES);
   localparam int unsigned RECIP_W    = PROD_W + 1;
   localparam int unsigned PCT_PROD_W = PROD_W + RECIP_W;
   localparam logic [31:0] POOL_BYTES = 32'(TABLE_ENTRIES * BLOCK_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(TABLE_ENTRIES - 1);
   // Rounded-up reciprocals: exact floor quotients over the full operand range
   localparam logic [16:0] IDX_RECIP = 17'(((64'd1 << IDX_SHIFT) + 64'(BLOCK_BYTES) - 64'd1)
                                          / 64'(BLOCK_BYTES));
   localparam logic [RECIP_W-1:0] PCT_RECIP = RECIP_W'(((64'd1 << PCT_SHIFT)
                                          + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b0_0000_0001,
      ST_CLEAR    = 9'b0_0000_0010,
      ST_SCAN     = 9'b0_0000_0100,
      ST_MARK     = 9'b0_0000_1000,
      ST_OFFS_IDX = 9'b0_0001_0000,
      ST_FREE_CHK = 9'b0_0010_0000,
      ST_FREE_CLR = 9'b0_0100_0000,
      ST_PCT_LOAD = 9'b0_1000_0000,
      ST_PCT_MUL  = 9'b1_0000_0000
   } state_type;

   // Control state
   state_type               state_ff,  state_in;
   logic [ADDR_W-1:0]       ptr_ff,    ptr_in;
   logic [ADDR_W-1:0]       scan_ff,   scan_in;
   logic [ADDR_W-1:0]       eval_ff,   eval_in;
   logic                    pend_ff,   pend_in;
   logic                    first_ff,  first_in;
   logic                    clr_rsp_ff, clr_rsp_in;
   logic [MAP_W-1:0]        used_ff,   used_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   // Payload state
   logic [MAP_W-1:0]        run_ff,    run_in;
   logic [RUNB_W-1:0]       run_bytes_ff, run_bytes_in;
   logic [MAP_W-1:0]        remain_ff, remain_in;
   logic [ADDR_W-1:0]       base_ff,   base_in;
   logic [MAP_W-1:0]        need_ff,   need_in;
   logic [1:0]              status_ff, status_in;
   logic [15:0]             grant_ff,  grant_in;
   logic [15:0]             bytes_ff,  bytes_in;
   logic [15:0]             offset_ff, offset_in;
   logic [PROD_W-1:0]       pct_num_ff, pct_num_in;
   bta_pkg::rsp_type        rsp_ff,    rsp_in;

   // Map memory
   logic [MAP_W-1:0]        block_map_ff [TABLE_ENTRIES];
   logic [MAP_W-1:0]        map_rd_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    mem_we;
   logic [MAP_W-1:0]        mem_wd;

   // Helpers
   logic [31:0]             grant_full;
   logic [MAP_W-1:0]        run_new;
   logic [RUNB_W-1:0]       run_bytes_new;
   logic                    run_fit;
   logic [MAP_W-1:0]        eff_remain;
   logic [MAP_W-1:0]        left_remain;
   logic [IDX_PROD_W-1:0]   idx_prod;
   logic [PCT_PROD_W-1:0]   pct_prod;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Scan bookkeeping: a run fits once its bytes cover the request
   assign run_new       = (map_rd_ff == '0) ? (run_ff + MAP_W'(1)) : '0;
   assign run_bytes_new = (map_rd_ff == '0) ? (run_bytes_ff + RUNB_W'(BLOCK_BYTES)) : '0;
   assign run_fit       = (32'(run_bytes_new) >= 32'(bytes_ff));

   // Offset to block index and used entries to percent by reciprocal multiply
   assign idx_prod = IDX_PROD_W'(offset_ff) * IDX_PROD_W'(IDX_RECIP);
   assign pct_prod = PCT_PROD_W'(pct_num_ff) * PCT_PROD_W'(PCT_RECIP);

   assign grant_full  = 32'(base_ff) * 32'(BLOCK_BYTES);
   assign eff_remain  = first_ff ? map_rd_ff : remain_ff;
   assign left_remain = eff_remain - MAP_W'(1);
   assign rd_addr     = (state_ff == ST_SCAN) ? scan_ff : ptr_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      scan_in       = scan_ff;
      eval_in       = eval_ff;
      pend_in       = pend_ff;
      first_in      = first_ff;
      clr_rsp_in    = clr_rsp_ff;
      used_in       = used_ff;
      rsp_strobe_in = 1'b0;
      run_in        = run_ff;
      run_bytes_in  = run_bytes_ff;
      remain_in     = remain_ff;
      base_in       = base_ff;
      need_in       = need_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      bytes_in      = bytes_ff;
      offset_in     = offset_ff;
      pct_num_in    = pct_num_ff;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wd        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               status_in = bta_pkg::STS_DONE;
               grant_in  = '0;
               unique case (req_data.action)
                  bta_pkg::ACT_ALLOC: begin
                     if (req_data.request_bytes == '0) begin
                        status_in = bta_pkg::STS_ZERO;
                        state_in  = ST_PCT_LOAD;
                     end else if (32'(req_data.request_bytes) > POOL_BYTES) begin
                        status_in = bta_pkg::STS_NO_RUN;
                        state_in  = ST_PCT_LOAD;
                     end else begin
                        bytes_in     = req_data.request_bytes;
                        scan_in      = LAST_ENTRY;
                        pend_in      = 1'b0;
                        run_in       = '0;
                        run_bytes_in = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  bta_pkg::ACT_FREE: begin
                     if (32'(req_data.release_offset) >= POOL_BYTES) begin
                        status_in = bta_pkg::STS_OUTSIDE;
                        state_in  = ST_PCT_LOAD;
                     end else begin
                        offset_in = req_data.release_offset;
                        state_in  = ST_OFFS_IDX;
                     end
                  end
                  bta_pkg::ACT_USAGE: begin
                     state_in = ST_PCT_LOAD;
                  end
                  bta_pkg::ACT_CLEAR: begin
                     ptr_in     = '0;
                     used_in    = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
               endcase
            end
         end

         // Sweep zeros through the map, one entry a cycle
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (ptr_ff == LAST_ENTRY) begin
               state_in = clr_rsp_ff ? ST_PCT_LOAD : ST_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end

         // Top-down scan: issue one read, count the entry read last cycle
         ST_SCAN: begin
            scan_in = (scan_ff == '0) ? '0 : (scan_ff - ADDR_W'(1));
            eval_in = scan_ff;
            pend_in = 1'b1;
            if (pend_ff) begin
               run_in       = run_new;
               run_bytes_in = run_bytes_new;
               if (run_fit) begin
                  ptr_in    = eval_ff;
                  base_in   = eval_ff;
                  need_in   = run_new;
                  remain_in = run_new;
                  state_in  = ST_MARK;
               end else if (eval_ff == '0) begin
                  status_in = bta_pkg::STS_NO_RUN;
                  state_in  = ST_PCT_LOAD;
               end
            end
         end

         // Write the run length into every entry of the run
         ST_MARK: begin
            mem_we   = 1'b1;
            mem_wd   = need_ff;
            used_in  = used_ff + MAP_W'(1);
            grant_in = grant_full[15:0];
            if (remain_ff == MAP_W'(1)) begin
               state_in = ST_PCT_LOAD;
            end else begin
               remain_in = remain_ff - MAP_W'(1);
               ptr_in    = ptr_ff + ADDR_W'(1);
            end
         end

         // Offset to block index
         ST_OFFS_IDX: begin
            ptr_in   = idx_prod[IDX_SHIFT +: ADDR_W];
            first_in = 1'b1;
            state_in = ST_FREE_CHK;
         end

         ST_FREE_CHK: begin
            state_in = ST_FREE_CLR;
         end

         // First read gives the count; each step clears one entry
         ST_FREE_CLR: begin
            first_in = 1'b0;
            if (eff_remain == '0) begin
               state_in = ST_PCT_LOAD;
            end else begin
               mem_we    = 1'b1;
               remain_in = left_remain;
               if (map_rd_ff != '0) begin
                  used_in = used_ff - MAP_W'(1);
               end
               if ((left_remain == '0) || (ptr_ff == LAST_ENTRY)) begin
                  state_in = ST_PCT_LOAD;
               end else begin
                  ptr_in   = ptr_ff + ADDR_W'(1);
                  state_in = ST_FREE_CHK;
               end
            end
         end

         // used * 100, then scaled down by the table size
         ST_PCT_LOAD: begin
            pct_num_in = PROD_W'(used_ff) * PROD_W'(bta_pkg::PERCENT_SCALE);
            state_in   = ST_PCT_MUL;
         end

         ST_PCT_MUL: begin
            rsp_in.status       = status_ff;
            rsp_in.grant_offset = grant_ff;
            rsp_in.used_percent = pct_prod[PCT_SHIFT +: 7];
            rsp_strobe_in       = 1'b1;
            state_in            = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ptr_ff        <= '0;
         scan_ff       <= '0;
         eval_ff       <= '0;
         pend_ff       <= 1'b0;
         first_ff      <= 1'b0;
         clr_rsp_ff    <= 1'b0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         scan_ff       <= scan_in;
         eval_ff       <= eval_in;
         pend_ff       <= pend_in;
         first_ff      <= first_in;
         clr_rsp_ff    <= clr_rsp_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      run_ff       <= run_in;
      run_bytes_ff <= run_bytes_in;
      remain_ff    <= remain_in;
      base_ff      <= base_in;
      need_ff      <= need_in;
      status_ff    <= status_in;
      grant_ff     <= grant_in;
      bytes_ff     <= bytes_in;
      offset_ff    <= offset_in;
      pct_num_ff   <= pct_num_in;
      rsp_ff       <= rsp_in;
   end

   // Map memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         block_map_ff[ptr_ff] <= mem_wd;
      end
      map_rd_ff <= block_map_ff[rd_addr];
   end

endmodule
